// File: rtl/sfd_pkg.sv
package sfd_pkg;

  // Depth of the command queue between the hunter and the result stage
  localparam int CmdDepth = 2;

  // Configuration register indexes
  localparam logic [2:0] REG_OWN_ID    = 3'd0;
  localparam logic [2:0] REG_SWARM     = 3'd1;
  localparam logic [2:0] REG_FORWARD   = 3'd2;
  localparam logic [2:0] REG_HEAD_ONE  = 3'd3;
  localparam logic [2:0] REG_HEAD_TWO  = 3'd4;
  localparam logic [2:0] REG_TAIL_ONE  = 3'd5;
  localparam logic [2:0] REG_TAIL_TWO  = 3'd6;

  // Command kinds
  localparam logic [1:0] KIND_ONE     = 2'd0;  // one content byte
  localparam logic [1:0] KIND_TWO     = 2'd1;  // held trailer byte, then content byte
  localparam logic [1:0] KIND_VERDICT = 2'd2;  // frame end

  // Verdict codes
  localparam logic [2:0] V_ACCEPTED  = 3'd0;
  localparam logic [2:0] V_OWN_ECHO  = 3'd1;
  localparam logic [2:0] V_BAD_SRC   = 3'd2;
  localparam logic [2:0] V_BAD_TGT   = 3'd3;
  localparam logic [2:0] V_UNKNOWN   = 3'd4;
  localparam logic [2:0] V_TOO_SHORT = 3'd5;

  localparam logic [7:0] ID_GROUND    = 8'd254;
  localparam logic [7:0] ID_BROADCAST = 8'd255;
  localparam logic [7:0] MSG_SPECIAL  = 8'd101;

  typedef struct packed {
    logic [7:0] own_node_id;
    logic [7:0] swarm_size;
    logic       forward_enable;
    logic [7:0] head_one;
    logic [7:0] head_two;
    logic [7:0] tail_one;
    logic [7:0] tail_two;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic       hdr_a;
    logic       hdr_b;
    logic       too_short;
    logic [7:0] msg_id;
    logic [7:0] dest_id;
    logic [7:0] source_id;
  } cmd_t;

  typedef struct packed {
    logic       is_frame_end;
    logic [7:0] data_byte;
    logic       is_header_byte;
    logic [2:0] verdict;
    logic       deliver_local;
    logic       forward_frame;
    logic [7:0] frame_msg_id;
    logic [7:0] frame_target_id;
    logic [7:0] frame_source_id;
    logic       last_of_run;
  } res_t;

  function automatic logic id_legal(input logic [7:0] id, input logic [7:0] swarm);
    id_legal = (id == ID_GROUND) || (id == ID_BROADCAST) ||
               ((id != 8'd0) && (id <= swarm));
  endfunction

  function automatic logic msg_known(input logic [7:0] msg);
    msg_known = (msg == 8'd1) || (msg == 8'd2) || (msg == 8'd3) ||
                (msg == MSG_SPECIAL) || (msg == ID_BROADCAST);
  endfunction

endpackage

// File: rtl/sfd_front.sv
module sfd_front (
  input  logic          clk,
  input  logic          rst,
  input  sfd_pkg::cfg_t cfg,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output logic          cmd_push,
  output sfd_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_GOT_H1   = 2'd1;
  localparam logic [1:0] ST_IN_FRAME = 2'd2;
  localparam logic [1:0] ST_GOT_T1   = 2'd3;

  logic [1:0] hunt_state, hunt_state_next;
  logic [1:0] header_count, header_count_next;
  logic [7:0] msg_id, msg_id_next;
  logic [7:0] dest_id, dest_id_next;
  logic [7:0] source_id, source_id_next;

  logic       is_h1, is_h2, is_t1, is_t2;
  logic       hdr_a, hdr_b;
  logic [1:0] count_a;
  logic       cmd_valid;
  logic       wr_a, wr_b;
  logic [7:0] wr_a_byte;

  // Classify: first match wins
  assign is_h1 = (rx_byte == cfg.head_one);
  assign is_h2 = !is_h1 && (rx_byte == cfg.head_two);
  assign is_t1 = !is_h1 && !is_h2 && (rx_byte == cfg.tail_one);
  assign is_t2 = !is_h1 && !is_h2 && !is_t1 && (rx_byte == cfg.tail_two);

  assign hdr_a   = (header_count != 2'd3);
  assign count_a = hdr_a ? header_count + 2'd1 : header_count;
  assign hdr_b   = (count_a != 2'd3);

  always_comb begin
    hunt_state_next   = hunt_state;
    header_count_next = header_count;
    msg_id_next       = msg_id;
    dest_id_next      = dest_id;
    source_id_next    = source_id;
    cmd_valid         = 1'b0;
    wr_a              = 1'b0;
    wr_b              = 1'b0;
    wr_a_byte         = rx_byte;
    cmd               = '0;
    cmd.hdr_a         = hdr_a;
    cmd.hdr_b         = hdr_b;
    cmd.too_short     = (header_count != 2'd3);
    cmd.msg_id        = msg_id;
    cmd.dest_id       = dest_id;
    cmd.source_id     = source_id;
    cmd.byte_b        = rx_byte;
    unique case (hunt_state)
      ST_IDLE: begin
        if (is_h1) hunt_state_next = ST_GOT_H1;
      end
      ST_GOT_H1: begin
        if (is_h2) begin
          hunt_state_next   = ST_IN_FRAME;
          header_count_next = 2'd0;
          msg_id_next       = '0;
          dest_id_next      = '0;
          source_id_next    = '0;
        end else if (!is_h1) begin
          hunt_state_next = ST_IDLE;
        end
      end
      ST_IN_FRAME: begin
        if (is_t1) begin
          hunt_state_next = ST_GOT_T1;
        end else begin
          cmd_valid = 1'b1;
          cmd.kind  = sfd_pkg::KIND_ONE;
          wr_a      = 1'b1;
        end
      end
      default: begin
        cmd_valid = 1'b1;
        wr_a_byte = cfg.tail_one;
        if (is_t1) begin
          cmd.kind = sfd_pkg::KIND_ONE;
          wr_a     = 1'b1;
        end else if (is_t2) begin
          cmd.kind        = sfd_pkg::KIND_VERDICT;
          hunt_state_next = ST_IDLE;
        end else begin
          cmd.kind        = sfd_pkg::KIND_TWO;
          wr_a            = 1'b1;
          wr_b            = 1'b1;
          hunt_state_next = ST_IN_FRAME;
        end
      end
    endcase
    cmd.byte_a = wr_a_byte;

    // Latch the header ids as the first three content bytes go past
    if (wr_a && hdr_a) begin
      header_count_next = count_a;
      unique case (header_count)
        2'd0:    msg_id_next    = wr_a_byte;
        2'd1:    dest_id_next   = wr_a_byte;
        default: source_id_next = wr_a_byte;
      endcase
    end
    if (wr_b && hdr_b) begin
      header_count_next = count_a + 2'd1;
      unique case (count_a)
        2'd1:    dest_id_next   = rx_byte;
        2'd2:    source_id_next = rx_byte;
        default: msg_id_next    = rx_byte;
      endcase
    end
  end

  assign cmd_push = accept && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_state   <= ST_IDLE;
      header_count <= 2'd0;
      msg_id       <= '0;
      dest_id      <= '0;
      source_id    <= '0;
    end else if (accept) begin
      hunt_state   <= hunt_state_next;
      header_count <= header_count_next;
      msg_id       <= msg_id_next;
      dest_id      <= dest_id_next;
      source_id    <= source_id_next;
    end
  end

endmodule

// File: rtl/sfd_cmd_fifo.sv
module sfd_cmd_fifo #(
  parameter int DEPTH = sfd_pkg::CmdDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  sfd_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output sfd_pkg::cmd_t rd_data,
  output logic          valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sfd_pkg::cmd_t   slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= bump(wr_ptr);
      if (rd_en) rd_ptr <= bump(rd_ptr);
      if (wr_en && !rd_en) count <= count + CW'(1);
      else if (!wr_en && rd_en) count <= count - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (!full || rd_en)) else $error("command written into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> valid) else $error("command taken from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("command count beyond depth");

endmodule

// File: rtl/sfd_back.sv
module sfd_back (
  input  logic          clk,
  input  logic          rst,
  input  sfd_pkg::cfg_t cfg,
  input  sfd_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          head_pop,
  input  logic          pop,
  output logic          out_valid,
  output sfd_pkg::res_t res
);

  logic          second;
  logic          advance;
  logic          load;
  logic [2:0]    verdict;
  sfd_pkg::res_t item;

  assign advance  = !out_valid || pop;
  assign load     = advance && head_valid;
  assign head_pop = load && !((head.kind == sfd_pkg::KIND_TWO) && !second);

  always_comb begin
    priority if (head.too_short)                            verdict = sfd_pkg::V_TOO_SHORT;
    else if (head.source_id == cfg.own_node_id)             verdict = sfd_pkg::V_OWN_ECHO;
    else if (!sfd_pkg::id_legal(head.source_id, cfg.swarm_size))
                                                            verdict = sfd_pkg::V_BAD_SRC;
    else if (!sfd_pkg::id_legal(head.dest_id, cfg.swarm_size))
                                                            verdict = sfd_pkg::V_BAD_TGT;
    else if (!sfd_pkg::msg_known(head.msg_id))              verdict = sfd_pkg::V_UNKNOWN;
    else                                                    verdict = sfd_pkg::V_ACCEPTED;
  end

  always_comb begin
    item = '0;
    unique case (head.kind)
      sfd_pkg::KIND_VERDICT: begin
        item.is_frame_end    = 1'b1;
        item.verdict         = verdict;
        item.deliver_local   = (verdict == sfd_pkg::V_ACCEPTED) &&
                               (head.msg_id != 8'd0) && (head.msg_id <= 8'd3) &&
                               ((head.dest_id == cfg.own_node_id) ||
                                (head.dest_id == sfd_pkg::ID_BROADCAST));
        item.forward_frame   = (verdict == sfd_pkg::V_ACCEPTED) && cfg.forward_enable;
        item.frame_msg_id    = head.msg_id;
        item.frame_target_id = head.dest_id;
        item.frame_source_id = head.source_id;
        item.last_of_run     = 1'b1;
      end
      sfd_pkg::KIND_TWO: begin
        item.data_byte      = second ? head.byte_b : head.byte_a;
        item.is_header_byte = second ? head.hdr_b : head.hdr_a;
        item.last_of_run    = second;
      end
      default: begin
        item.data_byte      = head.byte_a;
        item.is_header_byte = head.hdr_a;
        item.last_of_run    = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) res <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (advance) begin
      out_valid <= head_valid;
      if (load) second <= !head_pop;
    end
  end

  a_second_on_pair: assert property (@(posedge clk) disable iff (rst)
    second |-> (head_valid && (head.kind == sfd_pkg::KIND_TWO)))
    else $error("second half pending without a paired command");
  a_pair_split: assert property (@(posedge clk) disable iff (rst)
    (load && (head.kind == sfd_pkg::KIND_TWO) && !second) |=> second)
    else $error("paired command not split into two transfers");

endmodule

// File: rtl/serial_frame_deframer_with_id_filter.sv
// A taken byte's command is written into the command queue, then loads the result
//   register that drives the output ports once the result side can advance.
// Throughput: one byte per cycle while the command queue has room; results leave
//   at one per cycle while popped, one each for a held trailer and a content byte.
// Reset (rst, synchronous, active high): registers to defaults, hunter idle,
//   command queue and result register empty.
module serial_frame_deframer_with_id_filter #(
  parameter int CMD_DEPTH = sfd_pkg::CmdDepth
) (
  input  logic       clk,
  input  logic       rst,
  // byte input queue side
  input  logic       push,
  input  logic [7:0] rx_byte,
  output logic       full,
  // result queue side
  output logic       empty,
  input  logic       pop,
  output logic       is_frame_end,
  output logic [7:0] data_byte,
  output logic       is_header_byte,
  output logic [2:0] verdict,
  output logic       deliver_local,
  output logic       forward_frame,
  output logic [7:0] frame_msg_id,
  output logic [7:0] frame_target_id,
  output logic [7:0] frame_source_id,
  output logic       last_of_run,
  // configuration write port
  input  logic       cfg_write,
  input  logic [2:0] cfg_addr,
  input  logic [7:0] cfg_data
);

  sfd_pkg::cfg_t cfg;
  sfd_pkg::cmd_t cmd_in, cmd_head;
  sfd_pkg::res_t res;
  logic          accept;
  logic          cmd_push, cmd_pop, cmd_full, cmd_valid;
  logic          out_valid;

  // Configuration registers: hold their value until written. The user is to write
  // them only while no transfer is in flight; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_node_id    <= 8'd1;
      cfg.swarm_size     <= 8'd1;
      cfg.forward_enable <= 1'b0;
      cfg.head_one       <= 8'd170;
      cfg.head_two       <= 8'd85;
      cfg.tail_one       <= 8'd13;
      cfg.tail_two       <= 8'd10;
    end else if (cfg_write) begin
      unique case (cfg_addr)
        sfd_pkg::REG_OWN_ID:   cfg.own_node_id    <= cfg_data;
        sfd_pkg::REG_SWARM:    cfg.swarm_size     <= cfg_data;
        sfd_pkg::REG_FORWARD:  cfg.forward_enable <= cfg_data[0];
        sfd_pkg::REG_HEAD_ONE: cfg.head_one       <= cfg_data;
        sfd_pkg::REG_HEAD_TWO: cfg.head_two       <= cfg_data;
        sfd_pkg::REG_TAIL_ONE: cfg.tail_one       <= cfg_data;
        sfd_pkg::REG_TAIL_TWO: cfg.tail_two       <= cfg_data;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Front: take a byte whenever the command queue has room, whatever the
  // result side is doing. Every byte taken advances the hunter.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  sfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // Short queue between hunter and result stage, so each side stalls alone.
  sfd_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .valid   (cmd_valid)
  );

  // Back: expand each command into one or two result transfers, work out the
  // verdict at frame end, and hold the oldest result until it is popped.
  sfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (cmd_head),
    .head_valid (cmd_valid),
    .head_pop   (cmd_pop),
    .pop        (pop),
    .out_valid  (out_valid),
    .res        (res)
  );

  assign empty           = !out_valid;
  assign is_frame_end    = res.is_frame_end;
  assign data_byte       = res.data_byte;
  assign is_header_byte  = res.is_header_byte;
  assign verdict         = res.verdict;
  assign deliver_local   = res.deliver_local;
  assign forward_frame   = res.forward_frame;
  assign frame_msg_id    = res.frame_msg_id;
  assign frame_target_id = res.frame_target_id;
  assign frame_source_id = res.frame_source_id;
  assign last_of_run     = res.last_of_run;

endmodule
